/* src/ltc_pkg.sv */
// Shared types and constant tables for the lexical token classifier.
`default_nettype none

package ltc_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        CLS_OPERATOR   = 3'd0,
        CLS_KEYWORD    = 3'd1,
        CLS_SEPARATOR  = 3'd2,
        CLS_CONSTANT   = 3'd3,
        CLS_IDENTIFIER = 3'd4
    } token_class_t;

    localparam int NUM_CLASSES = 5;
    localparam int NUM_KW      = 9;
    localparam int NUM_OPS     = 7;
    localparam int NUM_SEPS    = 6;

    localparam byte_t CHAR_SPACE = 8'h20;
    localparam byte_t CHAR_TAB   = 8'h09;
    localparam byte_t CHAR_CR    = 8'h0D;
    localparam byte_t CHAR_ZERO  = 8'h30;
    localparam byte_t CHAR_NINE  = 8'h39;

    // keyword text, zero padded to 8 characters
    localparam byte_t KW_TEXT [NUM_KW][8] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd5, 3'd6, 3'd4, 3'd2, 3'd2, 3'd3, 3'd5, 3'd4
    };

    localparam byte_t OP_SET [NUM_OPS] = '{"-", "+", "*", "/", "<", ">", "="};
    localparam byte_t SEP_SET [NUM_SEPS] = '{"{", "}", "(", ")", ";", ","};

    typedef struct packed {
        byte_t char_in;
        logic  end_of_text;
    } in_word_t;

    typedef struct packed {
        token_class_t token_class;
        logic [3:0]   token_length;
        byte_t        first_char;
        logic [3:0]   keyword_index;
        logic [15:0]  class_count;
        logic         is_final;
    } out_word_t;

    typedef struct packed {
        token_class_t cls;
        logic [3:0]   kw_index;
    } class_info_t;

endpackage

`default_nettype wire

/* src/ltc_classify.sv */
// Classifies a closed token from its length, first character and keyword match flags.
`default_nettype none

module ltc_classify import ltc_pkg::*; #(
    parameter int LEN_W = 4
) (
    input  wire logic [LEN_W-1:0]  token_len,
    input  wire byte_t             start_char,
    input  wire logic [NUM_KW-1:0] kw_alive,
    output class_info_t            info
);

    logic       is_kw;
    logic [3:0] kw_idx;
    logic       is_op;
    logic       is_sep;
    logic       single;

    assign single = (token_len == LEN_W'(1));

    // first surviving keyword whose length equals the token length
    always_comb begin
        is_kw  = 1'b0;
        kw_idx = '0;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (kw_alive[k] && token_len == LEN_W'(KW_LEN[k])) begin
                is_kw  = 1'b1;
                kw_idx = 4'(k);
            end
        end
    end

    always_comb begin
        is_op = 1'b0;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (start_char == OP_SET[i]) begin
                is_op = 1'b1;
            end
        end
    end

    always_comb begin
        is_sep = 1'b0;
        for (int i = 0; i < NUM_SEPS; i++) begin
            if (start_char == SEP_SET[i]) begin
                is_sep = 1'b1;
            end
        end
    end

    always_comb begin
        info.kw_index = '0;
        if (single && is_op) begin
            info.cls = CLS_OPERATOR;
        end else if (is_kw) begin
            info.cls      = CLS_KEYWORD;
            info.kw_index = kw_idx;
        end else if (single && is_sep) begin
            info.cls = CLS_SEPARATOR;
        end else if (start_char >= CHAR_ZERO && start_char <= CHAR_NINE) begin
            info.cls = CLS_CONSTANT;
        end else begin
            info.cls = CLS_IDENTIFIER;
        end
    end

endmodule

`default_nettype wire

/* src/lexical_token_classifier.sv */
// Top level of the lexical token classifier: input register, scan state, result register.
//
// Input channel s_valid/s_ready/s_data carries one character word: char_in and
// end_of_text. Whitespace (tab, LF, VT, FF, CR, space) separates tokens. When a
// token closes, on whitespace or on a word with end_of_text set, one result word
// goes out on m_valid/m_ready/m_data: class, length, first character, keyword
// index and the updated saturating count for that class. Words that do not
// close a token produce nothing.
// Timing: a word is registered at acceptance, scanned by the scan stage once the
// result register is free, and its result, if any, is registered and shown on m_data.
// Throughput: one character word per cycle while the receiver does not stall, set by
// the single scan stage that updates the token state and the class counters.
// Reset (aresetn low, synchronous) empties both registers, clears the token
// state and all class counters.
// When the receiver stalls, the held result keeps the scan stage waiting; the
// input register then fills and s_ready drops until m_ready returns.
`default_nettype none

module lexical_token_classifier import ltc_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 15,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    // input register
    logic     in_valid_reg;
    in_word_t in_word_reg;

    // scan state
    logic [LEN_W-1:0]       len_reg,   len_next;
    byte_t                  start_reg, start_next;
    logic [NUM_KW-1:0]      alive_reg, alive_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_CLASSES];

    // result register
    logic      m_valid_reg;
    out_word_t m_data_reg;

    logic                   out_free;
    logic                   scan_fire;
    logic                   ws;
    logic                   emit;
    logic [LEN_W-1:0]       len_a;
    byte_t                  start_a;
    logic [NUM_KW-1:0]      alive_a;
    logic [NUM_KW-1:0]      kw_hit;
    class_info_t            info;
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic [COUNT_WIDTH+15:0] cnt_ext;
    logic [LEN_W+3:0]        len_ext;

    assign out_free  = !m_valid_reg || m_ready;
    assign scan_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || scan_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    assign ws = (in_word_reg.char_in == CHAR_SPACE) ||
                (in_word_reg.char_in >= CHAR_TAB && in_word_reg.char_in <= CHAR_CR);

    // per-keyword character match at the current position
    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            kw_hit[k] = (len_reg < LEN_W'(KW_LEN[k])) &&
                        (KW_TEXT[k][len_reg[2:0]] == in_word_reg.char_in);
        end
    end

    always_comb begin
        len_a   = len_reg;
        start_a = start_reg;
        alive_a = alive_reg;
        if (!ws) begin
            if (len_reg == '0) begin
                start_a = in_word_reg.char_in;
            end
            if (len_reg >= LEN_MAX) begin
                len_a   = LEN_MAX;
                alive_a = '0;
            end else begin
                alive_a = alive_reg & kw_hit;
                len_a   = len_reg + LEN_W'(1);
            end
        end
    end

    assign emit = (ws || in_word_reg.end_of_text) && (len_a != '0);

    ltc_classify #(
        .LEN_W (LEN_W)
    ) u_classify (
        .token_len  (len_a),
        .start_char (start_a),
        .kw_alive   (alive_a),
        .info       (info)
    );

    assign cnt_cur = cnt_reg[info.cls];
    assign cnt_upd = (cnt_cur != CNT_MAX) ? cnt_cur + COUNT_WIDTH'(1) : cnt_cur;
    assign cnt_ext = {16'd0, cnt_upd};
    assign len_ext = {4'd0, len_a};

    always_comb begin
        len_next   = len_a;
        start_next = start_a;
        alive_next = alive_a;
        if (emit || in_word_reg.end_of_text) begin
            len_next   = '0;
            alive_next = KW_ALL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            start_reg <= '0;
            alive_reg <= KW_ALL;
        end else if (scan_fire) begin
            len_reg   <= len_next;
            start_reg <= start_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (scan_fire && emit) begin
            cnt_reg[info.cls] <= cnt_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (scan_fire) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_fire && emit) begin
            m_data_reg.token_class   <= info.cls;
            m_data_reg.token_length  <= len_ext[3:0];
            m_data_reg.first_char    <= start_a;
            m_data_reg.keyword_index <= info.kw_index;
            m_data_reg.class_count   <= cnt_ext[15:0];
            m_data_reg.is_final      <= in_word_reg.end_of_text;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("token length above maximum");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_fire && in_word_reg.end_of_text |=> len_reg == '0 && alive_reg == KW_ALL)
        else $error("token state not cleared after end of text");

    a_kw_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_class != CLS_KEYWORD |-> m_data.keyword_index == 4'd0)
        else $error("keyword index on non-keyword token");

    a_stall_holds_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(len_reg) && $stable(alive_reg))
        else $error("scan state moved while result stalled");

endmodule

`default_nettype wire
